/* hw/rtl/gdc_pkg.sv */
`default_nettype none

package gdc_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int VALUE_BITS_DEF    = 16;

  // config register indexes
  localparam logic [2:0] CFG_LEG_ANGLE_0 = 3'd0;
  localparam logic [2:0] CFG_LEG_ANGLE_1 = 3'd1;
  localparam logic [2:0] CFG_LEG_ANGLE_2 = 3'd2;
  localparam logic [2:0] CFG_LEG_ANGLE_3 = 3'd3;
  localparam logic [2:0] CFG_LEG_REACH   = 3'd4;

  localparam logic [15:0] LEG_ANGLE_0_RST = 16'd8192;
  localparam logic [15:0] LEG_ANGLE_1_RST = 16'd24576;
  localparam logic [15:0] LEG_ANGLE_2_RST = 16'd40960;
  localparam logic [15:0] LEG_ANGLE_3_RST = 16'd57344;
  localparam logic [15:0] LEG_REACH_RST   = 16'd256;

  // walk direction codes
  localparam logic [2:0] DIR_ROT_POS = 3'd0;
  localparam logic [2:0] DIR_ROT_NEG = 3'd1;
  localparam logic [2:0] DIR_FWD     = 3'd2;
  localparam logic [2:0] DIR_BACK    = 3'd3;
  localparam logic [2:0] DIR_LEFT    = 3'd4;
  localparam logic [2:0] DIR_RIGHT   = 3'd5;

  // side flags carried along the CORDIC pipe
  typedef struct packed {
    logic zv;   // raw velocity zero
    logic sz;   // scaled velocity zero
    logic pos;  // turn rate > 0
    logic rot;  // reach exceeds turning radius
  } gdc_flags_t;

  // arctangent of 2^-i, 2^32 per turn
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // table entry rounded half up to ab bits (ab <= 24)
  function automatic logic [23:0] atan_entry(input int idx, input int ab);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ab));
    return 24'(sum >> (32 - ab));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/gait_direction_classifier_core.sv */
`default_nettype none

// Gait direction classifier. Each input transfer carries a velocity command
// (vel_x, vel_y) and a turn rate; each output transfer carries the walk
// direction (0 rotate plus, 1 rotate minus, 2 forward, 3 back, 4 left,
// 5 right) and the turning centre angle (16-bit binary angle). The block is a
// fully pipelined CORDIC: one transfer in and one out per clock while the
// output is not stalled; its registers are pre-rotation, one per
// micro-rotation, rounding and sector pick. Each stage has its own valid
// bit, so bubbles are squeezed out under back-pressure, and the input is
// taken while a result waits at the output if a stage is empty. The radius
// test (reach^2 * rate^2 > |v|^2 * 2^16) runs in a three-level side pipe.
// Config registers are written through cfg_* (always ready) and must only be
// changed while the pipe is empty.
module gait_direction_classifier_core #(
  parameter int ANGLE_BITS    = gdc_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = gdc_pkg::CORDIC_STAGES_DEF,
  parameter int VALUE_BITS    = gdc_pkg::VALUE_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // config write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_addr_i,
  input  wire  [15:0] cfg_data_i,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // vel_x[15:0], vel_y[31:16], turn_rate[47:32]
  // output stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // walk_direction[2:0], centre_angle[18:3], zero pad
);

  localparam int AB = ANGLE_BITS;
  localparam int VB = VALUE_BITS;
  localparam int N  = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
  localparam int W  = VB + 2;          // headroom for CORDIC gain
  localparam int P  = N + 2;           // index of the output register
  localparam logic [AB-1:0] HALF = AB'(1) << (AB - 1);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [15:0] leg_angle_0_q, leg_angle_1_q, leg_angle_2_q, leg_angle_3_q;
  logic [15:0] leg_reach_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leg_angle_0_q <= gdc_pkg::LEG_ANGLE_0_RST;
      leg_angle_1_q <= gdc_pkg::LEG_ANGLE_1_RST;
      leg_angle_2_q <= gdc_pkg::LEG_ANGLE_2_RST;
      leg_angle_3_q <= gdc_pkg::LEG_ANGLE_3_RST;
      leg_reach_q   <= gdc_pkg::LEG_REACH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        gdc_pkg::CFG_LEG_ANGLE_0: leg_angle_0_q <= cfg_data_i;
        gdc_pkg::CFG_LEG_ANGLE_1: leg_angle_1_q <= cfg_data_i;
        gdc_pkg::CFG_LEG_ANGLE_2: leg_angle_2_q <= cfg_data_i;
        gdc_pkg::CFG_LEG_ANGLE_3: leg_angle_3_q <= cfg_data_i;
        gdc_pkg::CFG_LEG_REACH:   leg_reach_q   <= cfg_data_i;
        default: ;                // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid bits and per-stage enables. A stage loads when it is empty or
  // the stage after it moves on.
  // ---------------------------------------------------------------------
  logic [P:0] vld_q, vld_d, en;

  always_comb begin
    en[P] = !vld_q[P] || m_axis_tready;
    for (int k = P - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d = {vld_q[P-1:0], s_axis_tvalid};
    for (int k = 0; k <= P; k++) begin
      if (!en[k]) vld_d[k] = vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[P];

  // ---------------------------------------------------------------------
  // Input unpack, scaling and pre-rotation (left half plane to right)
  // ---------------------------------------------------------------------
  logic signed [15:0] vel_x, vel_y, turn_rate;
  logic signed [VB-1:0] sc_x, sc_y;
  logic signed [W-1:0]  px, py;

  assign vel_x     = s_axis_tdata[15:0];
  assign vel_y     = s_axis_tdata[31:16];
  assign turn_rate = s_axis_tdata[47:32];

  generate
    if (VB >= 16) begin : g_up
      assign sc_x = VB'(vel_x) <<< (VB - 16);
      assign sc_y = VB'(vel_y) <<< (VB - 16);
    end else begin : g_down
      assign sc_x = VB'(vel_x >>> (16 - VB));
      assign sc_y = VB'(vel_y >>> (16 - VB));
    end
  endgenerate

  assign px = W'(sc_x);
  assign py = W'(sc_y);

  logic signed [W-1:0]  cx  [0:N];
  logic signed [W-1:0]  cy  [0:N];
  logic [AB-1:0]        cz  [0:N];
  gdc_pkg::gdc_flags_t  cf  [0:N];
  gdc_pkg::gdc_flags_t  pre_flg;
  logic                 rot;

  always_comb begin
    pre_flg.zv  = (vel_x == 16'sd0) && (vel_y == 16'sd0);
    pre_flg.sz  = (sc_x == '0) && (sc_y == '0);
    pre_flg.pos = !turn_rate[15] && (turn_rate != 16'sd0);
    pre_flg.rot = 1'b0;          // filled in once the radius pipe is done
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx[0] <= px[W-1] ? -px : px;
      cy[0] <= px[W-1] ? -py : py;
      cz[0] <= px[W-1] ? HALF : '0;
      cf[0] <= pre_flg;
    end
  end

  // Radius test: result lines up with pipe position 2
  gdc_radius u_radius (
    .clk_i       (clk_i),
    .en_i        (en[2:0]),
    .vel_x_i     (vel_x),
    .vel_y_i     (vel_y),
    .turn_rate_i (turn_rate),
    .leg_reach_i (leg_reach_q),
    .rot_o       (rot)
  );

  // ---------------------------------------------------------------------
  // CORDIC micro-rotations, one register each
  // ---------------------------------------------------------------------
  generate
    for (genvar k = 1; k <= N; k++) begin : g_stage
      gdc_pkg::gdc_flags_t flg_in;
      if (k == 3) begin : g_merge
        always_comb begin
          flg_in     = cf[k-1];
          flg_in.rot = rot;
        end
      end else begin : g_pass
        assign flg_in = cf[k-1];
      end

      gdc_cordic_stage #(
        .W   (W),
        .AB  (AB),
        .IDX (k - 1)
      ) u_stage (
        .clk_i (clk_i),
        .en_i  (en[k]),
        .x_i   (cx[k-1]),
        .y_i   (cy[k-1]),
        .z_i   (cz[k-1]),
        .flg_i (flg_in),
        .x_o   (cx[k]),
        .y_o   (cy[k]),
        .z_o   (cz[k]),
        .flg_o (cf[k])
      );
    end
  endgenerate

  // ---------------------------------------------------------------------
  // Angle finish and direction pick (positions N+1 and N+2)
  // ---------------------------------------------------------------------
  logic [2:0]  dir;
  logic [15:0] angle;

  gdc_classify #(
    .AB (AB)
  ) u_classify (
    .clk_i         (clk_i),
    .en_i          (en[P:P-1]),
    .z_i           (cz[N]),
    .flg_i         (cf[N]),
    .leg_angle_0_i (leg_angle_0_q),
    .leg_angle_1_i (leg_angle_1_q),
    .leg_angle_2_i (leg_angle_2_q),
    .leg_angle_3_i (leg_angle_3_q),
    .dir_o         (dir),
    .angle_o       (angle)
  );

  assign m_axis_tdata = {5'd0, angle, dir};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // an empty output register frees the whole pipe
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= gdc_pkg::DIR_RIGHT))
    else $error("walk direction code out of range");

  // a result only appears from an occupied stage before it
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[P-1]))
    else $error("result without a preceding item");

  // the pipe can only fill from accepted transfers
  a_fill_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("first stage filled without a transfer");

endmodule

`default_nettype wire

/* hw/rtl/gdc_cordic_stage.sv */
`default_nettype none

// One vectoring micro-rotation, registered.
module gdc_cordic_stage #(
  parameter int W   = 18,
  parameter int AB  = 16,
  parameter int IDX = 0
) (
  input  wire                      clk_i,
  input  wire                      en_i,
  input  wire logic signed [W-1:0] x_i,
  input  wire logic signed [W-1:0] y_i,
  input  wire logic [AB-1:0]       z_i,
  input  wire gdc_pkg::gdc_flags_t flg_i,
  output logic signed [W-1:0]      x_o,
  output logic signed [W-1:0]      y_o,
  output logic [AB-1:0]            z_o,
  output gdc_pkg::gdc_flags_t      flg_o
);

  localparam logic [AB-1:0] ATAN = AB'(gdc_pkg::atan_entry(IDX, AB));

  logic signed [W-1:0] dx, dy, x_d, y_d;
  logic [AB-1:0]       z_d;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      flg_o <= flg_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gdc_radius.sv */
`default_nettype none

// reach^2 * rate^2 > |v|^2 * 2^16, three register levels.
module gdc_radius (
  input  wire               clk_i,
  input  wire  [2:0]        en_i,
  input  wire logic signed [15:0] vel_x_i,
  input  wire logic signed [15:0] vel_y_i,
  input  wire logic signed [15:0] turn_rate_i,
  input  wire  [15:0]       leg_reach_i,
  output logic              rot_o
);

  logic [15:0] arate;
  logic [31:0] prod_q;
  logic [31:0] sqx_q, sqy_q;
  logic [63:0] lhs_q;
  logic [47:0] rhs_q;
  logic signed [31:0] sqx, sqy;

  assign arate = turn_rate_i[15] ? 16'(-turn_rate_i) : 16'(turn_rate_i);
  assign sqx   = vel_x_i * vel_x_i;
  assign sqy   = vel_y_i * vel_y_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= leg_reach_i * arate;
      sqx_q  <= 32'(sqx);
      sqy_q  <= 32'(sqy);
    end
    if (en_i[1]) begin
      lhs_q <= prod_q * prod_q;
      rhs_q <= {sqx_q + sqy_q, 16'd0};
    end
    if (en_i[2]) begin
      rot_o <= lhs_q > {16'd0, rhs_q};
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gdc_classify.sv */
`default_nettype none

// Quarter-turn offset, rounding to 16 bits, then sector pick.
module gdc_classify #(
  parameter int AB = 16
) (
  input  wire                      clk_i,
  input  wire  [1:0]               en_i,
  input  wire logic [AB-1:0]       z_i,
  input  wire gdc_pkg::gdc_flags_t flg_i,
  input  wire  [15:0]              leg_angle_0_i,
  input  wire  [15:0]              leg_angle_1_i,
  input  wire  [15:0]              leg_angle_2_i,
  input  wire  [15:0]              leg_angle_3_i,
  output logic [2:0]               dir_o,
  output logic [15:0]              angle_o
);

  localparam int SH = AB - 16;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  logic [AB-1:0] z_fin, z_adj;
  logic [15:0]   theta_w, theta_q;
  logic          pos_q, rot_q;
  logic [2:0]    dir_d;

  assign z_fin = flg_i.sz ? '0 : z_i;
  assign z_adj = flg_i.pos ? z_fin + QUARTER : z_fin - QUARTER;

  generate
    if (SH > 0) begin : g_round
      localparam logic [AB:0] RND = (AB + 1)'(1) << (SH - 1);
      logic [AB:0] rsum;
      assign rsum    = {1'b0, z_adj} + RND;
      assign theta_w = rsum[SH+15:SH];
    end else if (SH == 0) begin : g_same
      assign theta_w = 16'(z_adj);
    end else begin : g_widen
      assign theta_w = 16'(z_adj) << (-SH);
    end
  endgenerate

  always_comb begin
    if (rot_q) begin
      dir_d = pos_q ? gdc_pkg::DIR_ROT_POS : gdc_pkg::DIR_ROT_NEG;
    end else if (theta_q > leg_angle_0_i && theta_q < leg_angle_1_i) begin
      dir_d = pos_q ? gdc_pkg::DIR_FWD : gdc_pkg::DIR_BACK;
    end else if (theta_q > leg_angle_1_i && theta_q < leg_angle_2_i) begin
      dir_d = pos_q ? gdc_pkg::DIR_LEFT : gdc_pkg::DIR_RIGHT;
    end else if (theta_q > leg_angle_2_i && theta_q < leg_angle_3_i) begin
      dir_d = pos_q ? gdc_pkg::DIR_BACK : gdc_pkg::DIR_FWD;
    end else begin
      dir_d = pos_q ? gdc_pkg::DIR_RIGHT : gdc_pkg::DIR_LEFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      theta_q <= flg_i.zv ? 16'd0 : theta_w;
      pos_q   <= flg_i.pos;
      rot_q   <= flg_i.rot;
    end
    if (en_i[1]) begin
      dir_o   <= dir_d;
      angle_o <= theta_q;
    end
  end

endmodule

`default_nettype wire

/* bench/gait_direction_classifier_core_tb.sv */
`default_nettype none

module gait_direction_classifier_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // pipe depth as stated at the head of the core: pre-rotation, one register
  // per micro-rotation, rounding, sector pick
  localparam int CORDIC_DEPTH     = gdc_pkg::CORDIC_STAGES_DEF;
  localparam int PIPE_LATENCY     = CORDIC_DEPTH + 3;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int WATCHDOG_LIMIT   = 2000;

  // arctangent of 2^-i, 2^32 per turn; rounded to 16 bits when used
  localparam logic [31:0] ARCTAN_TURN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  typedef struct packed {
    logic [2:0]  dir;
    logic [15:0] angle;
  } gait_move_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i    = gdc_pkg::CFG_LEG_ANGLE_0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // vel_x[15:0], vel_y[31:16], turn_rate[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // walk_direction[2:0], centre_angle[18:3], zero pad

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  gait_direction_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the config registers and the store of expected moves
  // ---------------------------------------------------------------------------
  logic [15:0] leg_bearing [4];
  logic [15:0] leg_reach;
  gait_move_t  expected_moves [$];
  int          mismatch_count = 0;

  // idling controls for the sender and the receiver
  logic tx_idle_en  = 1'b1;
  logic rx_idle_en  = 1'b1;
  logic rx_hold_req = 1'b0;

  // Turning centre angle and walk direction for one command. The velocity
  // direction comes from a vectoring CORDIC (half-turn pre-rotation for x < 0,
  // floor shifts), then a quarter turn is added for a positive rate and taken
  // off otherwise. Zero velocity gives angle 0 with no quarter turn.
  function automatic gait_move_t classify_gait(input logic [15:0] vx_raw,
                                               input logic [15:0] vy_raw,
                                               input logic [15:0] rate_raw);
    longint      vx, vy, rate, arate, x, y, dx, dy;
    logic [31:0] rounded;
    logic [15:0] z;
    logic [63:0] reach_rate, lhs, rhs;
    logic        pos;
    int          i;
    gait_move_t  mv;
    vx   = longint'($signed(vx_raw));
    vy   = longint'($signed(vy_raw));
    rate = longint'($signed(rate_raw));
    pos  = rate > 0;
    if (vx == 0 && vy == 0) begin
      z = '0;
    end else begin
      x = vx;
      y = vy;
      z = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 16'h8000;
      end
      for (i = 0; i < CORDIC_DEPTH; i++) begin
        rounded = ARCTAN_TURN[i] + 32'h0000_8000;
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + rounded[31:16];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - rounded[31:16];
        end
      end
      z = pos ? z + 16'h4000 : z - 16'h4000;
    end
    mv.angle = z;

    // radius test on squares: reach^2 * rate^2 > |v|^2 * 2^16
    arate      = (rate < 0) ? -rate : rate;
    reach_rate = 64'(leg_reach) * 64'(arate);
    lhs        = reach_rate * reach_rate;
    rhs        = 64'(vx * vx + vy * vy) << 16;

    if (lhs > rhs)
      mv.dir = pos ? gdc_pkg::DIR_ROT_POS : gdc_pkg::DIR_ROT_NEG;
    else if (z > leg_bearing[0] && z < leg_bearing[1])
      mv.dir = pos ? gdc_pkg::DIR_FWD : gdc_pkg::DIR_BACK;
    else if (z > leg_bearing[1] && z < leg_bearing[2])
      mv.dir = pos ? gdc_pkg::DIR_LEFT : gdc_pkg::DIR_RIGHT;
    else if (z > leg_bearing[2] && z < leg_bearing[3])
      mv.dir = pos ? gdc_pkg::DIR_BACK : gdc_pkg::DIR_FWD;
    else
      mv.dir = pos ? gdc_pkg::DIR_RIGHT : gdc_pkg::DIR_LEFT;   // on a leg angle or out of order
    return mv;
  endfunction

  // mostly full range, with a fair share of zero, extremes and tiny values
  function automatic logic [15:0] pick_field();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'h8000;
          1: v = 16'h7FFF;
          2: v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      2: begin
        v = 16'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // One command transfer. Valid is left high on return so back-to-back
  // commands go out without a bubble; the gap or the drain lowers it.
  task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy,
                          input logic [15:0] rate);
    int gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rate, vy, vx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_moves.push_back(classify_gait(vx, vy, rate));
  endtask

  // stop offering, wait for every expected move, then let the pipe settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gdc_pkg::CFG_LEG_ANGLE_0: leg_bearing[0] = value;
      gdc_pkg::CFG_LEG_ANGLE_1: leg_bearing[1] = value;
      gdc_pkg::CFG_LEG_ANGLE_2: leg_bearing[2] = value;
      gdc_pkg::CFG_LEG_ANGLE_3: leg_bearing[3] = value;
      gdc_pkg::CFG_LEG_REACH:   leg_reach      = value;
      default: ;
    endcase
  endtask

  // full register set; only called with the pipe empty
  task automatic apply_config(input logic [15:0] a0, input logic [15:0] a1,
                              input logic [15:0] a2, input logic [15:0] a3,
                              input logic [15:0] reach);
    write_reg(gdc_pkg::CFG_LEG_ANGLE_0, a0);
    write_reg(gdc_pkg::CFG_LEG_ANGLE_1, a1);
    write_reg(gdc_pkg::CFG_LEG_ANGLE_2, a2);
    write_reg(gdc_pkg::CFG_LEG_ANGLE_3, a3);
    write_reg(gdc_pkg::CFG_LEG_REACH, reach);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // reset config: zero velocity, field extremes, radius boundary and every
  // walk direction for both signs of the rate
  task automatic test_directed_defaults();
    send_cmd(16'd0, 16'd0, 16'd0);            // zero velocity, zero rate
    send_cmd(16'd0, 16'd0, 16'd1);            // zero velocity rotates plus
    send_cmd(16'd0, 16'd0, 16'hFFFF);         // and minus
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cmd(16'h8000, 16'h8000, 16'h8000);
    send_cmd(16'h8000, 16'd0, 16'd0);         // straight back, half-turn branch
    send_cmd(16'd0, 16'h8000, 16'd100);
    send_cmd(16'hFFFF, 16'd0, 16'd0);
    send_cmd(16'd1, 16'hFFFF, 16'd0);
    send_cmd(16'd256, 16'd0, 16'd256);        // radius equal: no rotation
    send_cmd(16'd256, 16'd0, 16'd257);        // just inside the reach
    send_cmd(16'd1000, 16'd0, 16'd1);         // forward
    send_cmd(16'd0, 16'd1000, 16'd1);         // left
    send_cmd(16'hFC18, 16'd0, 16'd1);         // back
    send_cmd(16'd0, 16'hFC18, 16'd1);         // right
    send_cmd(16'd1000, 16'd0, 16'hFFFF);      // mirrored set for negative rate
    send_cmd(16'd0, 16'd1000, 16'hFFFF);
    send_cmd(16'hFC18, 16'd0, 16'hFFFF);
    send_cmd(16'd0, 16'hFC18, 16'hFFFF);
    wait_drained();
  endtask

  // angles landing on a leg angle, leg angles out of order, and the register
  // extremes
  task automatic test_leg_edges();
    gait_move_t probe;
    probe = classify_gait(16'd1000, 16'd0, 16'd1);
    apply_config(16'd0, probe.angle, 16'd40960, 16'd57344, 16'd256);
    send_cmd(16'd0, 16'd0, 16'd0);            // angle 0 sits on leg 0
    send_cmd(16'd1000, 16'd0, 16'd1);         // angle sits on leg 1
    send_cmd(16'd0, 16'd1000, 16'hFFFF);
    wait_drained();
    apply_config(16'd57344, 16'd40960, 16'd24576, 16'd8192, 16'd256);
    send_cmd(16'd1000, 16'd0, 16'd1);
    send_cmd(16'd0, 16'd1000, 16'hFFFF);
    send_cmd(16'hFC18, 16'h0100, 16'd0);
    wait_drained();
    apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);   // never rotates
    send_cmd(16'd0, 16'd0, 16'h7FFF);
    send_cmd(16'd5, 16'd7, 16'h8000);
    wait_drained();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(16'h7FFF, 16'h8000, 16'd1);
    send_cmd(16'h8000, 16'h8000, 16'hFFFF);
    send_cmd(16'h1234, 16'hABCD, 16'd0);
    wait_drained();
  endtask

  task automatic test_random_items(input int n_items);
    repeat (n_items) send_cmd(pick_field(), pick_field(), pick_field());
    wait_drained();
  endtask

  // several config settings, each followed by a batch of random commands
  task automatic test_random_phases();
    logic [15:0] a0, a1, a2, a3;
    apply_config(gdc_pkg::LEG_ANGLE_0_RST, gdc_pkg::LEG_ANGLE_1_RST,
                 gdc_pkg::LEG_ANGLE_2_RST, gdc_pkg::LEG_ANGLE_3_RST,
                 gdc_pkg::LEG_REACH_RST);
    test_random_items(160);
    repeat (2) begin
      // rising leg angles with random spacing
      a0 = 16'($urandom_range(0, 16383));
      a1 = a0 + 16'($urandom_range(1, 16383));
      a2 = a1 + 16'($urandom_range(1, 16383));
      a3 = a2 + 16'($urandom_range(1, 16383));
      apply_config(a0, a1, a2, a3, 16'($urandom_range(0, 1023)));
      test_random_items(160);
    end
    apply_config(16'd0, 16'd1, 16'hFFFE, 16'hFFFF, 16'd1);
    test_random_items(160);
  endtask

  // receiver holds off for a long stretch while commands keep coming, so the
  // pipe fills and the input stalls
  task automatic test_output_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (60) send_cmd(pick_field(), pick_field(), pick_field());
    tx_idle_en = 1'b1;
    wait_drained();
  endtask

  // sender pauses mid-stream until every expected move is back
  task automatic test_sender_pause();
    repeat (20) send_cmd(pick_field(), pick_field(), pick_field());
    wait_drained();
    repeat (20) send_cmd(pick_field(), pick_field(), pick_field());
    wait_drained();
  endtask

  // last part of the run: full rate on both sides
  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_items(100);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  initial begin
    leg_bearing[0] = gdc_pkg::LEG_ANGLE_0_RST;
    leg_bearing[1] = gdc_pkg::LEG_ANGLE_1_RST;
    leg_bearing[2] = gdc_pkg::LEG_ANGLE_2_RST;
    leg_bearing[3] = gdc_pkg::LEG_ANGLE_3_RST;
    leg_reach      = gdc_pkg::LEG_REACH_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_leg_edges();
    test_random_phases();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();

    if (expected_moves.size() != 0) begin
      $display("%0t: %0d expected moves never arrived", $time, expected_moves.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each output transfer against the oldest expected move
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    gait_move_t exp_mv;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual dir %0d angle %0d",
                 $time, m_axis_tdata[2:0], m_axis_tdata[18:3]);
        mismatch_count++;
      end else begin
        exp_mv = expected_moves.pop_front();
        if (m_axis_tdata[2:0] !== exp_mv.dir) begin
          $display("%0t: walk_direction mismatch, expected %0d, actual %0d",
                   $time, exp_mv.dir, m_axis_tdata[2:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[18:3] !== exp_mv.angle) begin
          $display("%0t: centre_angle mismatch, expected %0d, actual %0d",
                   $time, exp_mv.angle, m_axis_tdata[18:3]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer on any channel
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
